// ===== rtl/core/nfa_pkg.sv =====
package nfa_pkg;

    localparam int NUM_STATES  = 32;
    localparam int SYMBOL_BITS = 8;
    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int SYM_ROWS    = NUM_STATES << SYMBOL_BITS;
    localparam int SYM_AW      = STATE_W + SYMBOL_BITS;

    typedef logic [NUM_STATES-1:0]  t_mask;
    typedef logic [STATE_W-1:0]     t_state_idx;
    typedef logic [SYMBOL_BITS-1:0] t_symbol;
    typedef logic [SYM_AW-1:0]      t_sym_addr;
    typedef logic [1:0]             t_mode;

    localparam t_mode MODE_SYM_ROW = 2'd0;
    localparam t_mode MODE_EPS_ROW = 2'd1;
    localparam t_mode MODE_RESTART = 2'd2;
    localparam t_mode MODE_STEP    = 2'd3;

    localparam logic CFG_ENTRY  = 1'b0;
    localparam logic CFG_ACCEPT = 1'b1;

    localparam t_state_idx LAST_STATE = t_state_idx'(NUM_STATES - 1);

    typedef struct packed {
        logic       en;
        t_state_idx idx;
        t_mask      data;
    } t_eps_wr;

    typedef struct packed {
        logic      en;
        t_sym_addr addr;
        t_mask     data;
    } t_sym_wr;

endpackage

// ===== rtl/core/nfa_closure.sv =====
module nfa_closure (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nfa_pkg::t_eps_wr i_eps_wr,
    input  logic            i_start,
    input  nfa_pkg::t_mask  i_seed,
    output logic            o_done,
    output nfa_pkg::t_mask  o_set
);
    import nfa_pkg::*;

    t_mask               eps_mem [NUM_STATES];
    logic [NUM_STATES-1:0] r_vbits;
    t_mask               r_rd_data;
    logic                r_rd_vbit;
    logic                r_busy;
    logic                r_issue;
    logic                r_chk_vld;
    logic                r_changed;
    logic                r_done;
    t_state_idx          r_idx;
    t_state_idx          r_chk_idx;
    t_mask               r_set;
    t_mask               row;
    t_mask               n_set;
    logic                grew;
    logic                last_chk;

    always_ff @(posedge i_clk) begin
        if (i_eps_wr.en) begin
            eps_mem[i_eps_wr.idx] <= i_eps_wr.data;
        end
        r_rd_data <= eps_mem[r_idx];
        r_rd_vbit <= r_vbits[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits <= '0;
        end else if (i_eps_wr.en) begin
            r_vbits[i_eps_wr.idx] <= 1'b1;
        end
    end

    always_comb begin
        row      = r_rd_vbit ? r_rd_data : '0;
        n_set    = r_set | (r_set[r_chk_idx] ? row : '0);
        grew     = (n_set != r_set);
        last_chk = r_chk_vld && (r_chk_idx == LAST_STATE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issue   <= 1'b0;
            r_chk_vld <= 1'b0;
            r_changed <= 1'b0;
            r_done    <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_issue   <= 1'b1;
                r_idx     <= '0;
                r_chk_vld <= 1'b0;
                r_changed <= 1'b0;
            end else if (r_busy) begin
                r_chk_vld <= r_issue;
                if (r_issue) begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_STATE) begin
                        r_issue <= 1'b0;
                    end
                end
                if (r_chk_vld) begin
                    r_changed <= r_changed | grew;
                end
                // end of a pass: another pass if anything was added
                if (last_chk) begin
                    if (r_changed || grew) begin
                        r_issue   <= 1'b1;
                        r_idx     <= '0;
                        r_changed <= 1'b0;
                    end else begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_idx;
        if (i_start) begin
            r_set <= i_seed;
        end else if (r_chk_vld) begin
            r_set <= n_set;
        end
    end

    assign o_done = r_done;
    assign o_set  = r_set;

`ifndef ASSERT_OFF
    a_set_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> ((r_set & $past(r_set)) == $past(r_set)))
        else $error("closure set lost a state");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("closure restarted while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("closure done while busy");
    a_chk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> r_busy)
        else $error("row check outside a closure");
`endif

endmodule

// ===== rtl/core/nfa_sym_rows.sv =====
module nfa_sym_rows (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nfa_pkg::t_sym_wr   i_wr,
    input  nfa_pkg::t_sym_addr i_rd_addr,
    output nfa_pkg::t_mask     o_rd_data,
    output logic               o_ready
);
    import nfa_pkg::*;

    t_mask     sym_mem [SYM_ROWS];
    t_mask     r_rd_data;
    logic      r_clr_busy;
    t_sym_addr r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            sym_mem[r_clr_addr] <= '0;
        end else if (i_wr.en) begin
            sym_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= sym_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == t_sym_addr'(SYM_ROWS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clr_busy;

endmodule

// ===== rtl/core/nfa_state_set_stepper.sv =====
// NFA state-set stepper.
// Input words (s_axis) carry a mode in tuser: symbol-row write, epsilon-row write,
// restart, or step on a symbol. Every accepted word yields exactly one output word
// (m_axis): the active set in tdata, accept hit and empty flag in tuser.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data write entry_mask (0) or accept_mask (1);
// write only while the block is idle.
// One word is processed at a time. A row write goes straight to S_DONE, a restart
// runs one closure (S_CLO_F), and a step runs S_CLO_A, S_GATHER and S_CLO_F; the
// result is then registered on m_axis, and the next word can be accepted after that.
// An epsilon closure scans the 32 epsilon rows, one read per cycle from the
// epsilon memory, and repeats the pass until a pass adds nothing: 1 to 32 passes.
// Step = closure, a gather over the symbol-row memory (one row per state), then a
// second closure.
// Reset clears the current set and epsilon rows, then sweeps the symbol-row
// memory to zero; s_axis_tready stays low during the sweep.
// A finished result sits in the output register until taken; the next word is
// accepted meanwhile, and its result waits while m_axis_tready is low.
module nfa_state_set_stepper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // from_state[4:0], symbol[12:5], target_mask[44:13]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // active_set[31:0]
    output logic [1:0]  m_axis_tuser,  // accept_hit[0], is_dead[1]
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import nfa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLO_A  = 3'd1;
    localparam logic [2:0] S_GATHER = 3'd2;
    localparam logic [2:0] S_CLO_F  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic       [2:0] r_state;
    t_mask            r_entry;
    t_mask            r_accept;
    t_mask            r_cur;
    t_mask            r_closed;
    t_mask            r_moved;
    t_symbol          r_sym;
    t_state_idx       r_gidx;
    t_state_idx       r_gchk_idx;
    logic             r_gissue;
    logic             r_gchk_vld;
    logic             r_clo_start;
    t_mask            r_clo_seed;
    logic             r_out_valid;
    t_mask            r_out_set;
    logic             r_out_acc;
    logic             r_out_dead;

    logic             in_acc;
    t_mode            in_mode;
    t_state_idx       in_from;
    t_symbol          in_sym;
    t_mask            in_target;
    t_eps_wr          eps_wr;
    t_sym_wr          sym_wr;
    t_sym_addr        sym_rd_addr;
    t_mask            sym_rd_data;
    logic             sym_ready;
    logic             clo_done;
    t_mask            clo_set;
    t_mask            n_moved;
    logic             out_load;

    always_comb begin
        in_acc      = s_axis_tvalid && s_axis_tready;
        in_mode     = s_axis_tuser;
        in_from     = s_axis_tdata[4:0];
        in_sym      = s_axis_tdata[12:5];
        in_target   = s_axis_tdata[44:13];
        eps_wr.en   = in_acc && (in_mode == MODE_EPS_ROW);
        eps_wr.idx  = in_from;
        eps_wr.data = in_target;
        sym_wr.en   = in_acc && (in_mode == MODE_SYM_ROW);
        sym_wr.addr = {in_from, in_sym};
        sym_wr.data = in_target;
        sym_rd_addr = {r_gidx, r_sym};
        n_moved     = r_moved | (r_closed[r_gchk_idx] ? sym_rd_data : '0);
        out_load    = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    end

    nfa_sym_rows u_sym_rows (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (sym_wr),
        .i_rd_addr (sym_rd_addr),
        .o_rd_data (sym_rd_data),
        .o_ready   (sym_ready)
    );

    nfa_closure u_closure (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_eps_wr (eps_wr),
        .i_start  (r_clo_start),
        .i_seed   (r_clo_seed),
        .o_done   (clo_done),
        .o_set    (clo_set)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry  <= t_mask'(1);
            r_accept <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENTRY:  r_entry  <= i_cfg_data;
                CFG_ACCEPT: r_accept <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_clo_start <= 1'b0;
            r_gissue    <= 1'b0;
            r_gchk_vld  <= 1'b0;
            r_gidx      <= '0;
        end else begin
            r_clo_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (in_mode) inside
                            MODE_SYM_ROW, MODE_EPS_ROW: begin
                                r_state <= S_DONE;
                            end
                            MODE_RESTART: begin
                                r_clo_start <= 1'b1;
                                r_clo_seed  <= r_entry;
                                r_state     <= S_CLO_F;
                            end
                            MODE_STEP: begin
                                r_clo_start <= 1'b1;
                                r_clo_seed  <= r_cur;
                                r_sym       <= in_sym;
                                r_state     <= S_CLO_A;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CLO_A: begin
                    if (clo_done) begin
                        r_closed <= clo_set;
                        r_moved  <= '0;
                        r_gidx   <= '0;
                        r_gissue <= 1'b1;
                        r_state  <= S_GATHER;
                    end
                end
                S_GATHER: begin
                    r_gchk_vld <= r_gissue;
                    if (r_gissue) begin
                        r_gidx <= r_gidx + 1'b1;
                        if (r_gidx == LAST_STATE) begin
                            r_gissue <= 1'b0;
                        end
                    end
                    if (r_gchk_vld) begin
                        r_moved <= n_moved;
                        if (r_gchk_idx == LAST_STATE) begin
                            r_clo_start <= 1'b1;
                            r_clo_seed  <= n_moved;
                            r_state     <= S_CLO_F;
                        end
                    end
                end
                S_CLO_F: begin
                    if (clo_done) begin
                        r_cur   <= clo_set;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_gchk_idx <= r_gidx;
        if (out_load) begin
            r_out_set  <= r_cur;
            r_out_acc  <= |(r_cur & r_accept);
            r_out_dead <= (r_cur == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && sym_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_set;
    assign m_axis_tuser  = {r_out_dead, r_out_acc};

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import nfa_pkg::*;

    localparam int IDLE_LIMIT = 50000;
    localparam int PHASES     = 6;
    localparam int PHASE_WORDS = 140;

    typedef struct {
        t_mask active;
        logic  hit;
        logic  dead;
    } t_report;

    class t_scoreboard;
        t_mask       sym_rows [SYM_ROWS];
        t_mask       eps_rows [NUM_STATES];
        t_mask       live_set;
        t_mask       entry_states;
        t_mask       accept_states;
        t_report     awaited[$];
        int          faults;

        function new();
            foreach (sym_rows[i]) sym_rows[i] = '0;
            foreach (eps_rows[i]) eps_rows[i] = '0;
            live_set      = '0;
            entry_states  = t_mask'(1);
            accept_states = '0;
            faults        = 0;
        endfunction

        function t_mask eps_close(t_mask s);
            t_mask nxt;
            forever begin
                nxt = s;
                for (int i = 0; i < NUM_STATES; i++) begin
                    if (s[i]) nxt |= eps_rows[i];
                end
                if (nxt == s) return s;
                s = nxt;
            end
        endfunction

        function void set_reg(bit idx, t_mask value);
            if (idx == CFG_ENTRY) entry_states = value;
            else accept_states = value;
        endfunction

        function void note_word(t_mode mode, t_state_idx src, t_symbol sym, t_mask targets);
            t_mask       closed;
            t_mask       moved;
            t_report     rep;
            case (mode)
                MODE_SYM_ROW: sym_rows[{src, sym}] = targets;
                MODE_EPS_ROW: eps_rows[src] = targets;
                MODE_RESTART: live_set = eps_close(entry_states);
                default: begin
                    closed = eps_close(live_set);
                    moved  = '0;
                    for (int i = 0; i < NUM_STATES; i++) begin
                        if (closed[i]) moved |= sym_rows[{t_state_idx'(i), sym}];
                    end
                    live_set = eps_close(moved);
                end
            endcase
            rep.active = live_set;
            rep.hit    = |(live_set & accept_states);
            rep.dead   = (live_set == '0);
            awaited.insert(awaited.size(), rep);
        endfunction

        function void check_result(t_mask active, logic hit, logic dead);
            t_report     want;
            if (awaited.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: output word with none pending: set %h", $realtime, active);
                return;
            end
            want = awaited.pop_front();
            if (active !== want.active || hit !== want.hit || dead !== want.dead) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: mismatch set %h/%h accept %b/%b dead %b/%b (exp/got)",
                             $realtime, want.active, active, want.hit, hit, want.dead, dead);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [31:0] i_cfg_data = '0;

    t_scoreboard   sb = new();
    int            src_gap_pct = 28;
    int            sink_stall_pct = 61;
    int            quiet_cycles = 0;
    t_symbol       alphabet [4];

    nfa_state_set_stepper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_word(t_mode'(s_axis_tuser), s_axis_tdata[4:0], s_axis_tdata[12:5],
                         s_axis_tdata[44:13]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_word(input t_mode mode, input t_state_idx src, input t_symbol sym,
                             input t_mask targets);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = {3'b000, targets, sym, src};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input bit idx, input t_mask value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        sb.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    function automatic t_mask sparse_mask(int zero_pct, int dense_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return '0;
        if (r < zero_pct + dense_pct) return t_mask'($urandom);
        if (r == 99) return '1;
        return (t_mask'(1) << $urandom_range(0, NUM_STATES - 1))
             | (($urandom_range(0, 1) == 1) ? (t_mask'(1) << $urandom_range(0, 31)) : '0);
    endfunction

    function automatic t_symbol pick_symbol();
        if ($urandom_range(0, 99) < 85) return alphabet[$urandom_range(0, 3)];
        return t_symbol'($urandom);
    endfunction

    task automatic send_random_word();
        int         r;
        t_state_idx src;
        t_mask      noise;
        r     = $urandom_range(0, 99);
        src   = t_state_idx'($urandom);
        noise = t_mask'($urandom);
        if (r < 20)
            send_word(MODE_SYM_ROW, src, pick_symbol(), sparse_mask(15, 15));
        else if (r < 32)
            send_word(MODE_EPS_ROW, src, t_symbol'($urandom), sparse_mask(30, 8));
        else if (r < 42)
            send_word(MODE_RESTART, src, t_symbol'($urandom), noise);
        else
            send_word(MODE_STEP, src, pick_symbol(), noise);
    endtask

    initial begin
        foreach (alphabet[i]) alphabet[i] = t_symbol'($urandom);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset register values: entry = state 0, nothing accepting
        send_word(MODE_STEP,    5'd0,  8'h00, 32'h0);
        send_word(MODE_RESTART, 5'd0,  8'h00, 32'h0);
        send_word(MODE_SYM_ROW, 5'd0,  8'hFF, 32'hFFFF_FFFF);
        send_word(MODE_SYM_ROW, 5'd31, 8'h00, 32'h8000_0001);
        send_word(MODE_EPS_ROW, 5'd0,  8'h00, 32'h0000_0010);
        send_word(MODE_EPS_ROW, 5'd4,  8'h00, 32'h0000_0008);
        send_word(MODE_EPS_ROW, 5'd3,  8'h00, 32'h0000_0004);
        send_word(MODE_EPS_ROW, 5'd2,  8'h00, 32'h0000_0002);
        send_word(MODE_EPS_ROW, 5'd31, 8'h00, 32'h8000_0000);
        send_word(MODE_RESTART, 5'd31, 8'hFF, 32'hFFFF_FFFF);
        send_word(MODE_STEP,    5'd31, 8'hFF, 32'hFFFF_FFFF);
        send_word(MODE_STEP,    5'd0,  8'h00, 32'h0);
        send_word(MODE_STEP,    5'd10, 8'h55, 32'h1234_5678);
        send_word(MODE_STEP,    5'd21, 8'hAA, 32'h0);
        send_word(MODE_SYM_ROW, 5'd0,  8'hFF, 32'h0);
        send_word(MODE_EPS_ROW, 5'd2,  8'h00, 32'h0);
        send_word(MODE_RESTART, 5'd0,  8'h00, 32'h0);
        send_word(MODE_STEP,    5'd0,  8'hFF, 32'h0);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin write_reg(CFG_ENTRY, 32'h0);         write_reg(CFG_ACCEPT, '1); end
                1: begin write_reg(CFG_ENTRY, '1);            write_reg(CFG_ACCEPT, 32'h0); end
                2: begin write_reg(CFG_ENTRY, $urandom & $urandom);
                         write_reg(CFG_ACCEPT, $urandom); end
                3: begin write_reg(CFG_ENTRY, 32'h8000_0000); write_reg(CFG_ACCEPT, 32'h1); end
                4: begin write_reg(CFG_ENTRY, $urandom);      write_reg(CFG_ACCEPT, $urandom); end
                default: begin write_reg(CFG_ENTRY, 32'h1);   write_reg(CFG_ACCEPT, 32'h0000_FFFF); end
            endcase
            if (p >= 4) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end else if (p >= 2) begin
                src_gap_pct    = 61;
                sink_stall_pct = 28;
            end
            repeat (PHASE_WORDS) send_random_word();
        end

        drain();
        repeat (200) @(negedge i_clk);
        if (sb.faults == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/nfa_pkg.sv
rtl/core/nfa_closure.sv
rtl/core/nfa_sym_rows.sv
rtl/core/nfa_state_set_stepper.sv
test/tb_top.sv
